### sv/iirq15_pkg.sv
`timescale 1ns / 1ps

package iirq15_pkg;

  // Fixed-point format and default sizing.
  localparam int Q_SHIFT       = 15;
  localparam int DEF_MAX_ORDER = 8;
  localparam int PROD_W        = 48;
  localparam int ACC_W         = 32;

  // Input word operation codes.
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ORDER            = 3'd0,
    REG_GAIN_IN          = 3'd1,
    REG_FEEDBACK_SHIFT   = 3'd2,
    REG_GAIN_OUT         = 3'd3,
    REG_OUT_SHIFT_ADJUST = 3'd4
  } reg_index_t;

  // What the multiply-accumulate unit does with a product once it is registered.
  typedef enum logic [2:0] {
    MAC_NONE   = 3'd0,
    MAC_LOAD_A = 3'd1,
    MAC_SUB_A  = 3'd2,
    MAC_ADD_B  = 3'd3,
    MAC_HOLD   = 3'd4
  } mac_op_t;

endpackage

### sv/iirq15_mac.sv
`timescale 1ns / 1ps

module iirq15_mac import iirq15_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [ACC_W-1:0]  mul_x,
  input  logic signed [15:0]       mul_y,
  input  mac_op_t                  mac_op,
  output logic signed [PROD_W-1:0] prod,
  output logic [ACC_W-1:0]         acc_a,
  output logic [ACC_W-1:0]         acc_b
);

  logic signed [PROD_W-1:0] product;
  mac_op_t                  prod_op;
  logic [ACC_W-1:0]         term;

  // One shared signed multiplier, registered before any accumulation.
  assign product = mul_x * mul_y;

  always_ff @(posedge clk) begin
    if (mac_op != MAC_NONE) begin
      prod <= product;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_op <= MAC_NONE;
    end else begin
      prod_op <= mac_op;
    end
  end

  // Arithmetic shift right by the Q format, keeping the low 32 bits.
  assign term = prod[Q_SHIFT+ACC_W-1:Q_SHIFT];

  // Feedback sum in acc_a, feed-forward sum in acc_b; both wrap at 32 bits.
  always_ff @(posedge clk) begin
    unique case (prod_op)
      MAC_LOAD_A: begin
        acc_a <= term;
        acc_b <= '0;
      end
      MAC_SUB_A: begin
        acc_a <= acc_a - term;
      end
      MAC_ADD_B: begin
        acc_b <= acc_b + term;
      end
      MAC_NONE, MAC_HOLD: begin
      end
      default: begin
      end
    endcase
  end

endmodule

### sv/iir_direct_form2_q15_filter.sv
`timescale 1ns / 1ps
// A filter word's result is registered in S_DONE, after its tap, feedback and output gain states.
// No new word is taken until the sequencer is back in S_IDLE; the single shared
// multiplier takes two products per tap plus gain and b0 products.
// A coefficient load word is taken in S_IDLE, leaves the sequencer there and gives no result.
// Reset (rst, synchronous): registers to their defaults, delay line and position cleared.

module iir_direct_form2_q15_filter import iirq15_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic signed [15:0] sample,
  input  logic [4:0]         coef_index,
  input  logic signed [15:0] coef_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] filtered
);

  localparam int NCOEF = 2 * MAX_ORDER + 1;
  localparam int CI_W  = $clog2(NCOEF);
  localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int N_W   = $clog2(MAX_ORDER + 1);
  localparam logic [CI_W-1:0] B0_ADDR = CI_W'(MAX_ORDER);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_TAP_A = 7'b0000010,
    S_TAP_B = 7'b0000100,
    S_FB    = 7'b0001000,
    S_GWAIT = 7'b0010000,
    S_GOUT  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [3:0]         order;
  logic signed [15:0] gain_in;
  logic [3:0]         feedback_shift;
  logic signed [15:0] gain_out;
  logic [3:0]         out_shift_adjust;

  // Filter state.
  logic [15:0]      delay_line [MAX_ORDER];
  logic [IDX_W-1:0] line_position;
  logic [IDX_W-1:0] start;
  logic [IDX_W-1:0] cur;
  logic [N_W-1:0]   k;
  logic [N_W-1:0]   n_eff;

  // Coefficient memory.
  logic signed [15:0] coef_mem [NCOEF];
  logic signed [15:0] coef_q;
  logic [CI_W-1:0]    coef_raddr;
  logic               coef_we;

  // Shared multiply-accumulate interface.
  logic signed [ACC_W-1:0]  mul_x;
  logic signed [15:0]       mul_y;
  mac_op_t                  mac_op;
  logic signed [PROD_W-1:0] prod;
  logic [ACC_W-1:0]         acc_a;
  logic [ACC_W-1:0]         acc_b;
  logic [ACC_W-1:0]         fb_sh;
  logic signed [15:0]       tap_state;

  logic                     in_accept;
  logic [3:0]               out_sh;
  logic signed [PROD_W-1:0] out_scaled;

  // Step one place back around a circular line of n entries.
  function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] pos,
                                                 input logic [N_W-1:0] n);
    logic [N_W-1:0] last;
    last = n - N_W'(1);
    if (pos == '0 || 32'(pos) >= 32'(n)) begin
      return IDX_W'(last);
    end
    return pos - IDX_W'(1);
  endfunction

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Order in use: zero acts as one, anything above the maximum is clamped.
  always_comb begin
    if (order == 4'd0) begin
      n_eff = N_W'(1);
    end else if (32'(order) > MAX_ORDER) begin
      n_eff = N_W'(MAX_ORDER);
    end else begin
      n_eff = N_W'(order);
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      order            <= 4'd8;
      gain_in          <= 16'sh7FFF;
      feedback_shift   <= 4'd0;
      gain_out         <= 16'sh7FFF;
      out_shift_adjust <= 4'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ORDER:            order            <= cfg_data[3:0];
        REG_GAIN_IN:          gain_in          <= cfg_data;
        REG_FEEDBACK_SHIFT:   feedback_shift   <= cfg_data[3:0];
        REG_GAIN_OUT:         gain_out         <= cfg_data;
        REG_OUT_SHIFT_ADJUST: out_shift_adjust <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Coefficient memory: written by load words, read into a register in the state before use.
  assign coef_we = in_accept && (op == OP_LOAD) && (32'(coef_index) < NCOEF);

  always_comb begin
    unique case (state)
      S_IDLE:  coef_raddr = CI_W'(n_eff) - CI_W'(1);
      S_TAP_A: coef_raddr = B0_ADDR + CI_W'(k);
      S_TAP_B: coef_raddr = (k > N_W'(1)) ? (CI_W'(k) - CI_W'(2)) : B0_ADDR;
      default: coef_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[CI_W'(coef_index)] <= coef_value;
    end
    coef_q <= coef_mem[coef_raddr];
  end

  // Operand selection for the shared multiplier.
  assign tap_state = delay_line[cur];
  assign fb_sh     = acc_a << feedback_shift;

  always_comb begin
    mul_x  = '0;
    mul_y  = '0;
    mac_op = MAC_NONE;
    unique case (state)
      S_IDLE: begin
        mul_x = ACC_W'(sample);
        mul_y = gain_in;
        if (in_accept && op == OP_FILTER) begin
          mac_op = MAC_LOAD_A;
        end
      end
      S_TAP_A: begin
        mul_x  = ACC_W'(tap_state);
        mul_y  = coef_q;
        mac_op = MAC_SUB_A;
      end
      S_TAP_B: begin
        mul_x  = ACC_W'(tap_state);
        mul_y  = coef_q;
        mac_op = MAC_ADD_B;
      end
      S_FB: begin
        mul_x  = fb_sh;
        mul_y  = coef_q;
        mac_op = MAC_ADD_B;
      end
      S_GOUT: begin
        mul_x  = acc_b;
        mul_y  = gain_out;
        mac_op = MAC_HOLD;
      end
      S_GWAIT, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  iirq15_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .mul_x  (mul_x),
    .mul_y  (mul_y),
    .mac_op (mac_op),
    .prod   (prod),
    .acc_a  (acc_a),
    .acc_b  (acc_b)
  );

  // Output gain shift is 15 minus the adjustment.
  assign out_sh     = 4'(Q_SHIFT) - out_shift_adjust;
  assign out_scaled = prod >>> out_sh;

  // Sequencer: taps run oldest state first, two products per tap.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      line_position <= '0;
      start         <= '0;
      cur           <= '0;
      k             <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < MAX_ORDER; i++) begin
        delay_line[i] <= '0;
      end
    end else begin
      // A new word enters the output register when it is free or being emptied.
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept && op == OP_FILTER) begin
            start <= step_back(line_position, n_eff);
            cur   <= step_back(line_position, n_eff);
            k     <= n_eff;
            state <= S_TAP_A;
          end
        end
        S_TAP_A: begin
          state <= S_TAP_B;
        end
        S_TAP_B: begin
          cur <= step_back(cur, n_eff);
          k   <= k - N_W'(1);
          if (k == N_W'(1)) begin
            state <= S_FB;
          end else begin
            state <= S_TAP_A;
          end
        end
        S_FB: begin
          delay_line[start] <= fb_sh[15:0];
          line_position     <= start;
          state             <= S_GWAIT;
        end
        S_GWAIT: begin
          state <= S_GOUT;
        end
        S_GOUT: begin
          state <= S_DONE;
        end
        S_DONE: begin
          // Hold the product until the output register is free.
          if (!out_valid || !out_stall) begin
            filtered <= out_scaled[15:0];
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
